@@ rtl/core/hgs_pkg.sv @@
// Shared types, constants and microcode table for the hydro governor step block.
`default_nettype none
package hgs_pkg;

    localparam int WORD_BITS    = 32;
    localparam int FRAC_BITS    = 24;
    localparam int GAIN_BITS    = FRAC_BITS + 1;
    localparam int OPND_BITS    = WORD_BITS + 1;
    localparam int PROD_BITS    = 2 * OPND_BITS;
    localparam int CFG_IDX_BITS = 4;
    localparam int UC_STEPS     = 13;
    localparam int STEP_BITS    = $clog2(UC_STEPS);

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;
    typedef logic [STEP_BITS-1:0]    t_step;

    localparam t_cfg_idx CFG_SPEED_REF   = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_GAIN_ONE    = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_GAIN_TWO    = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_WEIGHT_ONE  = t_cfg_idx'(3);
    localparam t_cfg_idx CFG_WEIGHT_TWO  = t_cfg_idx'(4);
    localparam t_cfg_idx CFG_POWER_REF   = t_cfg_idx'(5);
    localparam t_cfg_idx CFG_POWER_UPPER = t_cfg_idx'(6);
    localparam t_cfg_idx CFG_POWER_LOWER = t_cfg_idx'(7);

    localparam logic signed [WORD_BITS-1:0] FX_ONE = WORD_BITS'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        LIM_NONE  = 2'd0,
        LIM_UPPER = 2'd1,
        LIM_LOWER = 2'd2
    } t_limit;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_OUT
    } t_op;

    typedef enum logic [3:0] {
        SRC_ZERO,
        SRC_SPEED,
        SRC_SREF,
        SRC_ELAST,
        SRC_X1,
        SRC_X2,
        SRC_T,
        SRC_M,
        SRC_G1,
        SRC_G2,
        SRC_B1,
        SRC_B2,
        SRC_PREF
    } t_src;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_T,
        DST_M,
        DST_X1,
        DST_X2,
        DST_ELAST
    } t_dst;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_WAIT_IN,
        JMP_WAIT_OUT
    } t_jmp;

    typedef struct packed {
        t_op  op;
        t_src src_a;
        t_src src_b;
        t_dst dst;
        t_jmp jmp;
    } t_ctrl;

    typedef struct packed {
        t_ctrl ctrl;
        logic  fire;
    } t_ucmd;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } t_seq_stat;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] speed_ref;
        logic        [GAIN_BITS-1:0] gain_one;
        logic        [GAIN_BITS-1:0] gain_two;
        logic signed [WORD_BITS-1:0] weight_one;
        logic signed [WORD_BITS-1:0] weight_two;
        logic signed [WORD_BITS-1:0] power_ref;
        logic signed [WORD_BITS-1:0] power_upper;
        logic signed [WORD_BITS-1:0] power_lower;
    } t_cfg;

    // Microprogram: speed load, lag updates, weighted sum plus power reference, new error, clamp and deliver.
    function automatic t_ctrl uc_rom(input t_step step);
        t_ctrl w;
        unique case (step)
            t_step'(0):  w = '{OP_LOAD, SRC_ZERO,  SRC_ZERO,  DST_NONE,  JMP_WAIT_IN};
            t_step'(1):  w = '{OP_SUB,  SRC_ELAST, SRC_X1,    DST_T,     JMP_NEXT};
            t_step'(2):  w = '{OP_MUL,  SRC_G1,    SRC_T,     DST_M,     JMP_NEXT};
            t_step'(3):  w = '{OP_ADD,  SRC_X1,    SRC_M,     DST_X1,    JMP_NEXT};
            t_step'(4):  w = '{OP_SUB,  SRC_ELAST, SRC_X2,    DST_T,     JMP_NEXT};
            t_step'(5):  w = '{OP_MUL,  SRC_G2,    SRC_T,     DST_M,     JMP_NEXT};
            t_step'(6):  w = '{OP_ADD,  SRC_X2,    SRC_M,     DST_X2,    JMP_NEXT};
            t_step'(7):  w = '{OP_MUL,  SRC_B1,    SRC_X1,    DST_T,     JMP_NEXT};
            t_step'(8):  w = '{OP_MUL,  SRC_B2,    SRC_X2,    DST_M,     JMP_NEXT};
            t_step'(9):  w = '{OP_ADD,  SRC_T,     SRC_M,     DST_T,     JMP_NEXT};
            t_step'(10): w = '{OP_ADD,  SRC_PREF,  SRC_T,     DST_T,     JMP_NEXT};
            t_step'(11): w = '{OP_SUB,  SRC_SREF,  SRC_SPEED, DST_ELAST, JMP_NEXT};
            t_step'(12): w = '{OP_OUT,  SRC_T,     SRC_ZERO,  DST_NONE,  JMP_WAIT_OUT};
            default:     w = '{OP_NOP,  SRC_ZERO,  SRC_ZERO,  DST_NONE,  JMP_WAIT_OUT};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/hgs_sequencer.sv @@
// Microcode sequencer: step counter, control ROM and wait jumps.
`default_nettype none
module hgs_sequencer (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire hgs_pkg::t_seq_stat i_stat,
    output hgs_pkg::t_ucmd         o_ucmd
);
    import hgs_pkg::*;

    t_step r_step;
    t_step n_step;
    t_ctrl w_ctrl;
    logic  w_fire;

    always_comb begin
        w_ctrl = uc_rom(r_step);
        unique case (w_ctrl.jmp)
            JMP_WAIT_IN:  w_fire = i_stat.in_valid;
            JMP_WAIT_OUT: w_fire = i_stat.out_free;
            default:      w_fire = 1'b1;
        endcase
        n_step = r_step;
        if (w_fire) begin
            // the delivery step closes the program and returns to the wait
            n_step = (w_ctrl.jmp == JMP_WAIT_OUT) ? '0 : t_step'(r_step + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ucmd = '{ctrl: w_ctrl, fire: w_fire};

endmodule
`default_nettype wire

@@ rtl/core/hgs_datapath.sv @@
// Datapath: state registers, saturating adder, shared multiplier, clamp, output register.
`default_nettype none
module hgs_datapath (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire hgs_pkg::t_ucmd                        i_ucmd,
    input  wire hgs_pkg::t_cfg                         i_cfg,
    input  wire logic signed [hgs_pkg::WORD_BITS-1:0]  i_speed_sample,
    input  wire logic                                  i_out_stall,
    output logic                                       o_out_free,
    output logic                                       o_out_valid,
    output logic signed [hgs_pkg::WORD_BITS-1:0]       o_power_out,
    output logic [1:0]                                 o_limit_state
);
    import hgs_pkg::*;

    logic signed [WORD_BITS-1:0] r_speed;
    logic signed [WORD_BITS-1:0] r_t;
    logic signed [WORD_BITS-1:0] r_m;
    logic signed [WORD_BITS-1:0] r_x1;
    logic signed [WORD_BITS-1:0] r_x2;
    logic signed [WORD_BITS-1:0] r_elast;
    logic                        r_out_valid;
    logic signed [WORD_BITS-1:0] r_power;
    t_limit                      r_limit;

    logic signed [OPND_BITS-1:0] w_a;
    logic signed [OPND_BITS-1:0] w_b;
    logic signed [OPND_BITS:0]   w_sum;
    logic signed [PROD_BITS-1:0] w_prod;
    logic [PROD_BITS-FRAC_BITS-WORD_BITS:0] w_prod_hi;
    logic signed [WORD_BITS-1:0] w_res;
    logic signed [WORD_BITS-1:0] w_clip;
    t_limit                      w_limit;
    logic                        w_exec;

    function automatic logic signed [OPND_BITS-1:0] sext(input logic signed [WORD_BITS-1:0] v);
        return {v[WORD_BITS-1], v};
    endfunction

    function automatic logic signed [OPND_BITS-1:0] pick(input t_src s,
                                                         input logic signed [WORD_BITS-1:0] sp,
                                                         input logic signed [WORD_BITS-1:0] t,
                                                         input logic signed [WORD_BITS-1:0] m,
                                                         input logic signed [WORD_BITS-1:0] x1,
                                                         input logic signed [WORD_BITS-1:0] x2,
                                                         input logic signed [WORD_BITS-1:0] el,
                                                         input t_cfg c);
        logic signed [OPND_BITS-1:0] v;
        unique case (s)
            SRC_SPEED: v = sext(sp);
            SRC_SREF:  v = sext(c.speed_ref);
            SRC_ELAST: v = sext(el);
            SRC_X1:    v = sext(x1);
            SRC_X2:    v = sext(x2);
            SRC_T:     v = sext(t);
            SRC_M:     v = sext(m);
            SRC_G1:    v = {{(OPND_BITS-GAIN_BITS){1'b0}}, c.gain_one};
            SRC_G2:    v = {{(OPND_BITS-GAIN_BITS){1'b0}}, c.gain_two};
            SRC_B1:    v = sext(c.weight_one);
            SRC_B2:    v = sext(c.weight_two);
            SRC_PREF:  v = sext(c.power_ref);
            default:   v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        w_a = pick(i_ucmd.ctrl.src_a, r_speed, r_t, r_m, r_x1, r_x2, r_elast, i_cfg);
        w_b = pick(i_ucmd.ctrl.src_b, r_speed, r_t, r_m, r_x1, r_x2, r_elast, i_cfg);

        if (i_ucmd.ctrl.op == OP_SUB) begin
            w_sum = {w_a[OPND_BITS-1], w_a} - {w_b[OPND_BITS-1], w_b};
        end else begin
            w_sum = {w_a[OPND_BITS-1], w_a} + {w_b[OPND_BITS-1], w_b};
        end

        // product floors by the fraction shift, then saturates to the word
        w_prod    = w_a * w_b;
        w_prod_hi = w_prod[PROD_BITS-1:FRAC_BITS+WORD_BITS-1];

        if (i_ucmd.ctrl.op == OP_MUL) begin
            if ((&w_prod_hi) || !(|w_prod_hi)) begin
                w_res = w_prod[FRAC_BITS+WORD_BITS-1:FRAC_BITS];
            end else begin
                w_res = w_prod[PROD_BITS-1] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                            : {1'b0, {(WORD_BITS-1){1'b1}}};
            end
        end else begin
            if ((&w_sum[OPND_BITS:WORD_BITS-1]) || !(|w_sum[OPND_BITS:WORD_BITS-1])) begin
                w_res = w_sum[WORD_BITS-1:0];
            end else begin
                w_res = w_sum[OPND_BITS] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                         : {1'b0, {(WORD_BITS-1){1'b1}}};
            end
        end

        // upper limit first, lower limit wins when the limits cross
        w_clip  = r_t;
        w_limit = LIM_NONE;
        if (r_t > i_cfg.power_upper) begin
            w_clip  = i_cfg.power_upper;
            w_limit = LIM_UPPER;
        end
        if (w_clip < i_cfg.power_lower) begin
            w_clip  = i_cfg.power_lower;
            w_limit = LIM_LOWER;
        end
    end

    assign w_exec = i_ucmd.fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1        <= '0;
            r_x2        <= '0;
            r_elast     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_exec && (i_ucmd.ctrl.op == OP_OUT)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_exec) begin
                unique case (i_ucmd.ctrl.dst)
                    DST_X1:    r_x1    <= w_res;
                    DST_X2:    r_x2    <= w_res;
                    DST_ELAST: r_elast <= w_res;
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            unique case (i_ucmd.ctrl.dst)
                DST_T:   r_t <= w_res;
                DST_M:   r_m <= w_res;
                default: ;
            endcase
            if (i_ucmd.ctrl.op == OP_LOAD) begin
                r_speed <= i_speed_sample;
            end
            if (i_ucmd.ctrl.op == OP_OUT) begin
                r_power <= w_clip;
                r_limit <= w_limit;
            end
        end
    end

    assign o_out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid   = r_out_valid;
    assign o_power_out   = r_power;
    assign o_limit_state = r_limit;

endmodule
`default_nettype wire

@@ rtl/core/hydro_governor_step.sv @@
// Top level of the hydro governor step: config registers, sequencer and datapath.
// A 13-step microprogram drives one shared 33x33 multiplier and one saturating adder,
// one operation per step.
// A held result stalls only the last step; the next request is taken once it is delivered.
// Reset (synchronous, active low) clears the lag states, the last error, the step counter
// and the output valid, and loads the register defaults.
`default_nettype none
module hydro_governor_step (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // speed sample request channel
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic signed [hgs_pkg::WORD_BITS-1:0]  i_speed_sample,
    // governor power result channel
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic signed [hgs_pkg::WORD_BITS-1:0]       o_power_out,
    output logic [1:0]                                 o_limit_state,
    // configuration write channel
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [hgs_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  wire logic [hgs_pkg::WORD_BITS-1:0]         i_cfg_data
);
    import hgs_pkg::*;

    t_cfg      r_cfg;
    t_ucmd     w_ucmd;
    t_seq_stat w_stat;
    logic      w_out_free;

    // Registers are always writable; software must write only while idle (not enforced).
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_ref   <= FX_ONE;
            r_cfg.gain_one    <= '0;
            r_cfg.gain_two    <= '0;
            r_cfg.weight_one  <= '0;
            r_cfg.weight_two  <= '0;
            r_cfg.power_ref   <= '0;
            r_cfg.power_upper <= FX_ONE;
            r_cfg.power_lower <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SPEED_REF:   r_cfg.speed_ref   <= i_cfg_data;
                CFG_GAIN_ONE:    r_cfg.gain_one    <= i_cfg_data[GAIN_BITS-1:0];
                CFG_GAIN_TWO:    r_cfg.gain_two    <= i_cfg_data[GAIN_BITS-1:0];
                CFG_WEIGHT_ONE:  r_cfg.weight_one  <= i_cfg_data;
                CFG_WEIGHT_TWO:  r_cfg.weight_two  <= i_cfg_data;
                CFG_POWER_REF:   r_cfg.power_ref   <= i_cfg_data;
                CFG_POWER_UPPER: r_cfg.power_upper <= i_cfg_data;
                CFG_POWER_LOWER: r_cfg.power_lower <= i_cfg_data;
                default:         ;  // indexes past the list are dropped
            endcase
        end
    end

    assign w_stat = '{in_valid: i_in_valid, out_free: w_out_free};

    hgs_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ucmd  (w_ucmd)
    );

    hgs_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ucmd         (w_ucmd),
        .i_cfg          (r_cfg),
        .i_speed_sample (i_speed_sample),
        .i_out_stall    (i_out_stall),
        .o_out_free     (w_out_free),
        .o_out_valid    (o_out_valid),
        .o_power_out    (o_power_out),
        .o_limit_state  (o_limit_state)
    );

    // Requests are taken only at the wait step of the program.
    assign o_in_stall = (w_ucmd.ctrl.jmp != JMP_WAIT_IN);

    // A taken request starts the program, so the next cycle must stall.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request channel open right after an accepted request");

    // A new result appears only from a fired delivery step.
    a_result_from_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_ucmd.fire && (w_ucmd.ctrl.op == OP_OUT)))
        else $error("result valid without a delivery step");

    // The delivery step waits while a held result is stalled, and that result stays.
    a_hold_at_delivery: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ucmd.ctrl.jmp == JMP_WAIT_OUT && !w_out_free) |=>
        (o_out_valid && $stable(o_power_out) && $stable(o_limit_state)))
        else $error("held result overwritten at the delivery step");

endmodule
`default_nettype wire
